// File: rtl/core/lagsel_pkg.sv
package lagsel_pkg;

    // fixed field widths
    localparam int CNT_W       = 5;
    localparam int HASH_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int PORT_W      = 8;
    localparam int CMD_W       = 2;

    // remainder unit: bits of hash consumed per cycle
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = HASH_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // flag entry is {running, allowed}
    localparam int FLAG_W                 = 2;
    localparam logic [FLAG_W-1:0] FLAG_RESET = 2'b01;

    localparam int DEFAULT_MAX_MEMBERS = 16;
    localparam int DEFAULT_PORT_COUNT  = 256;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic write_member;
        logic update_flags;
        logic load_sel;
        logic div_step;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic count_zero;
        logic div_last;
        logic hit;
        logic scan_over;
    } t_dp_sts;

endpackage

// File: rtl/core/lagsel_ram.sv
module lagsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lagsel_ctrl.sv
module lagsel_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lagsel_pkg::CMD_W-1:0]   i_command,
    input  lagsel_pkg::t_dp_sts            i_sts,
    output lagsel_pkg::t_dp_cmd            o_cmd,
    output logic                           o_busy,
    output logic                           o_valid
);

    import lagsel_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start && (i_command == CMD_SELECT)) begin
                    n_state = i_sts.count_zero ? ST_REPORT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.hit || i_sts.scan_over) n_state = ST_REPORT;
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        CMD_SELECT: o_cmd.load_sel     = 1'b1;
                        CMD_WRITE:  o_cmd.write_member = 1'b1;
                        CMD_UPDATE: o_cmd.update_flags = 1'b1;
                        default:    o_cmd              = '0;
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_REPORT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // a hit during the scan is reported in the next cycle
    a_hit_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.hit) |=> o_valid)
        else $error("hit not reported");

    // the remainder unit hands over to the scan
    a_div_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_last) |=> (r_state == ST_SCAN))
        else $error("scan did not follow remainder");

endmodule

// File: rtl/core/lagsel_dp.sv
module lagsel_dp #(
    parameter int MAX_MEMBERS = lagsel_pkg::DEFAULT_MAX_MEMBERS,
    parameter int PORT_COUNT  = lagsel_pkg::DEFAULT_PORT_COUNT,
    localparam int SW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1,
    localparam int AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lagsel_pkg::t_dp_cmd              i_cmd,
    output lagsel_pkg::t_dp_sts              o_sts,
    input  logic                             i_cfg_we,
    input  logic [lagsel_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  logic [lagsel_pkg::HASH_W-1:0]    i_flow_hash,
    input  logic [lagsel_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic [lagsel_pkg::PORT_W-1:0]    i_port_number,
    input  logic                             i_port_running,
    input  logic                             i_port_allowed,
    output logic                             o_found,
    output logic [lagsel_pkg::SLOT_W-1:0]    o_chosen_slot,
    output logic [lagsel_pkg::PORT_W-1:0]    o_chosen_port,
    output logic                             o_mem_we,
    output logic [SW-1:0]                    o_mem_waddr,
    output logic [lagsel_pkg::PORT_W-1:0]    o_mem_wdata,
    output logic [SW-1:0]                    o_mem_raddr,
    input  logic [lagsel_pkg::PORT_W-1:0]    i_mem_rdata,
    output logic                             o_flag_we,
    output logic [AW-1:0]                    o_flag_waddr,
    output logic [lagsel_pkg::FLAG_W-1:0]    o_flag_wdata,
    output logic [AW-1:0]                    o_flag_raddr,
    input  logic [lagsel_pkg::FLAG_W-1:0]    i_flag_rdata
);

    import lagsel_pkg::*;

    // configuration
    logic [CNT_W-1:0]     r_member_count;
    logic [CNT_W-1:0]     w_count;

    // remainder unit and scan pointer
    logic [HASH_W-1:0]    r_shift;
    logic [HASH_W-1:0]    r_h;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CNT_W-1:0]     r_issued;
    logic [CNT_W-1:0]     w_rem_div;
    logic [CNT_W-1:0]     w_rem_inc;
    logic [CNT_W-1:0]     w_rem_next;
    logic                 w_can_issue;

    // scan pipeline: member read, then flag read
    logic                 r_v1;
    logic                 r_v2;
    logic [CNT_W-1:0]     r_s1;
    logic [CNT_W-1:0]     r_s2;
    logic [PORT_W-1:0]    r_p2;
    logic                 r_inr2;
    logic                 w_hit;

    // result
    logic                 r_found;
    logic [SLOT_W-1:0]    r_res_slot;
    logic [PORT_W-1:0]    r_res_port;

    logic [AW-1:0]        r_clr_addr;

    logic [SW+CNT_W-1:0]  w_rem_ext;
    logic [SW+SLOT_W-1:0] w_slot_ext;
    logic [AW+PORT_W-1:0] w_port_ext;
    logic [AW+PORT_W-1:0] w_mport_ext;

    assign w_count = (32'(r_member_count) > 32'(MAX_MEMBERS)) ?
                     CNT_W'(MAX_MEMBERS) : r_member_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member_count <= '0;
        end else if (i_cfg_we) begin
            r_member_count <= i_cfg_wdata;
        end
    end

    // several restoring remainder steps per cycle, msb first
    always_comb begin
        logic [CNT_W:0] t;
        w_rem_div = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            t = {w_rem_div, r_shift[HASH_W-1-k]};
            if (t >= {1'b0, w_count}) begin
                t = t - {1'b0, w_count};
            end
            w_rem_div = t[CNT_W-1:0];
        end
    end

    assign w_can_issue = (r_issued < w_count);
    assign w_rem_inc   = r_rem + CNT_W'(1);
    // hash wrap at 2^32 restarts at slot 0
    assign w_rem_next  = (r_h == '1) ? '0 :
                         ((w_rem_inc == w_count) ? '0 : w_rem_inc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sel) begin
            r_shift    <= i_flow_hash;
            r_h        <= i_flow_hash;
            r_rem      <= '0;
            r_div_cnt  <= '0;
            r_issued   <= '0;
        end else if (i_cmd.div_step) begin
            r_shift    <= r_shift << DIV_BITS;
            r_rem      <= w_rem_div;
            r_div_cnt  <= r_div_cnt + DIV_CNT_W'(1);
        end else if (i_cmd.scan_step && w_can_issue) begin
            r_h        <= r_h + HASH_W'(1);
            r_rem      <= w_rem_next;
            r_issued   <= r_issued + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step && w_can_issue;
            r_v2 <= i_cmd.scan_step && r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1   <= r_rem;
        r_s2   <= r_s1;
        r_p2   <= i_mem_rdata;
        r_inr2 <= (32'(i_mem_rdata) < 32'(PORT_COUNT));
    end

    assign w_hit = r_v2 && r_inr2 && i_flag_rdata[1] && i_flag_rdata[0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sel) begin
            r_found    <= 1'b0;
            r_res_slot <= '0;
            r_res_port <= '0;
        end else if (i_cmd.scan_step && w_hit) begin
            r_found    <= 1'b1;
            r_res_slot <= r_s2[SLOT_W-1:0];
            r_res_port <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // memory ports
    assign w_rem_ext   = {{SW{1'b0}}, r_rem};
    assign w_slot_ext  = {{SW{1'b0}}, i_slot_index};
    assign w_port_ext  = {{AW{1'b0}}, i_port_number};
    assign w_mport_ext = {{AW{1'b0}}, i_mem_rdata};

    assign o_mem_we    = i_cmd.write_member && (32'(i_slot_index) < 32'(MAX_MEMBERS));
    assign o_mem_waddr = w_slot_ext[SW-1:0];
    assign o_mem_wdata = i_port_number;
    assign o_mem_raddr = w_rem_ext[SW-1:0];

    always_comb begin
        if (i_cmd.clear_step) begin
            o_flag_we    = 1'b1;
            o_flag_waddr = r_clr_addr;
            o_flag_wdata = FLAG_RESET;
        end else begin
            o_flag_we    = i_cmd.update_flags &&
                           (32'(i_port_number) < 32'(PORT_COUNT));
            o_flag_waddr = w_port_ext[AW-1:0];
            o_flag_wdata = {i_port_running, i_port_allowed};
        end
    end

    assign o_flag_raddr = w_mport_ext[AW-1:0];

    // status
    assign o_sts.clear_last = (r_clr_addr == AW'(PORT_COUNT - 1));
    assign o_sts.count_zero = (w_count == '0);
    assign o_sts.div_last   = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_sts.hit        = w_hit;
    assign o_sts.scan_over  = !w_can_issue && !r_v1 && !r_v2;

    assign o_found       = r_found;
    assign o_chosen_slot = r_res_slot;
    assign o_chosen_port = r_res_port;

    // scan pointer stays inside the group
    a_slot_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && w_can_issue) |-> (r_rem < w_count))
        else $error("scan slot outside group");

    // flag stage only follows a member read
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("flag stage without member read");

    // a chosen member is always on a real port
    a_found_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (32'(r_res_port) < 32'(PORT_COUNT)))
        else $error("chosen port out of range");

endmodule

// File: rtl/core/lag_member_select_failover_top.sv
// link-aggregation member selection with failover, one group
//
// command channel: an item is taken on a clock edge with i_start high and
// o_busy low. i_command picks select by hash, write member slot or update
// port flags; an unused code is taken and dropped.
// write and update items finish at the accept edge and give no result;
// o_busy stays low, so another item may follow in the next cycle.
// a select item gives one result: o_valid is high for exactly one cycle
// with o_found, o_chosen_slot and o_chosen_port; the receiver cannot stall.
// a select runs from the accept edge to the strobe: the remainder unit
// (4 hash bits a cycle) reduces the hash modulo the member count, then a scan
// issues one member a cycle through a two-stage read (member table, then port
// flags) until a hit or until every candidate is read; then the report state
// raises the strobe. an empty group reports in the cycle after accept.
// one select at a time, o_busy high until the strobe.
// member_count is written on i_cfg_we; the user must write it only while
// idle, which the block does not enforce. reset: the port flag memory is
// swept to running=0, allowed=1, one entry a cycle, with o_busy high;
// member slots read as unknown until written.
module lag_member_select_failover_top #(
    parameter int MAX_MEMBERS = lagsel_pkg::DEFAULT_MAX_MEMBERS,
    parameter int PORT_COUNT  = lagsel_pkg::DEFAULT_PORT_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [lagsel_pkg::CMD_W-1:0]     i_command,
    input  logic [lagsel_pkg::HASH_W-1:0]    i_flow_hash,
    input  logic [lagsel_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic [lagsel_pkg::PORT_W-1:0]    i_port_number,
    input  logic                             i_port_running,
    input  logic                             i_port_allowed,
    input  logic                             i_cfg_we,
    input  logic [lagsel_pkg::CNT_W-1:0]     i_cfg_wdata,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [lagsel_pkg::SLOT_W-1:0]    o_chosen_slot,
    output logic [lagsel_pkg::PORT_W-1:0]    o_chosen_port
);

    import lagsel_pkg::*;

    localparam int SW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // member table port
    logic              w_mem_we;
    logic [SW-1:0]     w_mem_waddr;
    logic [PORT_W-1:0] w_mem_wdata;
    logic [SW-1:0]     w_mem_raddr;
    logic [PORT_W-1:0] w_mem_rdata;

    // port flag memory port
    logic              w_flag_we;
    logic [AW-1:0]     w_flag_waddr;
    logic [FLAG_W-1:0] w_flag_wdata;
    logic [AW-1:0]     w_flag_raddr;
    logic [FLAG_W-1:0] w_flag_rdata;

    lagsel_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_busy    (o_busy),
        .o_valid   (o_valid)
    );

    lagsel_dp #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .PORT_COUNT  (PORT_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_flow_hash    (i_flow_hash),
        .i_slot_index   (i_slot_index),
        .i_port_number  (i_port_number),
        .i_port_running (i_port_running),
        .i_port_allowed (i_port_allowed),
        .o_found        (o_found),
        .o_chosen_slot  (o_chosen_slot),
        .o_chosen_port  (o_chosen_port),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata),
        .o_flag_we      (w_flag_we),
        .o_flag_waddr   (w_flag_waddr),
        .o_flag_wdata   (w_flag_wdata),
        .o_flag_raddr   (w_flag_raddr),
        .i_flag_rdata   (w_flag_rdata)
    );

    // egress port of each member slot
    lagsel_ram #(
        .WIDTH (PORT_W),
        .DEPTH (MAX_MEMBERS)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // {running, allowed} per port
    lagsel_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (PORT_COUNT)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (w_flag_we),
        .i_waddr (w_flag_waddr),
        .i_wdata (w_flag_wdata),
        .i_raddr (w_flag_raddr),
        .o_rdata (w_flag_rdata)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lagsel_pkg::*;

    // command code with no function, taken and dropped by the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int MEMBER_SLOTS   = DEFAULT_MAX_MEMBERS;
    localparam int PORT_SLOTS     = DEFAULT_PORT_COUNT;
    // longest select: remainder unit, 16 candidates, scan pipe, report
    localparam int SETTLE_CYCLES  = 40;
    // the clearing sweep after reset covers every port; everything else is far shorter
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 12;
    localparam int ITEMS_PER_PHASE = 67;

    // one selection outcome as the block reports it
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [PORT_W-1:0] port;
    } t_member_pick;

    // mirror of the group: member table, port flags and member count;
    // every accepted select queues the pick that the group gives at that point
    class member_pick_board;
        logic [PORT_W-1:0] slot_port [MEMBER_SLOTS];
        bit                running   [PORT_SLOTS];
        bit                allowed   [PORT_SLOTS];
        int unsigned       group_size;
        t_member_pick      expected_picks [$];
        int                errors;

        function new();
            foreach (slot_port[s]) slot_port[s] = '0;
            foreach (running[p]) begin
                running[p] = 1'b0;
                allowed[p] = 1'b1;
            end
            group_size = 0;
            errors     = 0;
        endfunction

        function void set_group_size(logic [CNT_W-1:0] n);
            group_size = n;
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // scan from hash mod count onward, first running and unblocked member wins
        function t_member_pick predict_pick(logic [HASH_W-1:0] hash);
            t_member_pick pick;
            int unsigned  eff;
            int unsigned  s;
            logic [31:0]  probe;
            pick = '0;
            eff  = (group_size > MEMBER_SLOTS) ? MEMBER_SLOTS : group_size;
            for (int i = 0; i < eff; i++) begin
                probe = hash + 32'(i);
                s     = probe % eff;
                if (running[slot_port[s]] && allowed[slot_port[s]]) begin
                    pick.found = 1'b1;
                    pick.slot  = s[SLOT_W-1:0];
                    pick.port  = slot_port[s];
                    break;
                end
            end
            return pick;
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [HASH_W-1:0] hash,
                                logic [SLOT_W-1:0] slot, logic [PORT_W-1:0] port,
                                logic run, logic allow);
            case (cmd)
                CMD_SELECT: expected_picks.push_back(predict_pick(hash));
                CMD_WRITE:  slot_port[slot] = port;
                CMD_UPDATE: begin
                    running[port] = run;
                    allowed[port] = allow;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic found, logic [SLOT_W-1:0] slot,
                                   logic [PORT_W-1:0] port);
            t_member_pick want;
            if (expected_picks.size() == 0) begin
                $error("unexpected result: found %0d slot %0d port %0d", found, slot, port);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                errors++;
            end
            if (slot !== want.slot) begin
                $error("chosen_slot: expected %0d, got %0d", want.slot, slot);
                errors++;
            end
            if (port !== want.port) begin
                $error("chosen_port: expected %0d, got %0d", want.port, port);
                errors++;
            end
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  command      = CMD_SELECT;
    logic [HASH_W-1:0] flow_hash    = '0;
    logic [SLOT_W-1:0] slot_index   = '0;
    logic [PORT_W-1:0] port_number  = '0;
    logic              port_running = 1'b0;
    logic              port_allowed = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata    = '0;
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] chosen_slot;
    logic [PORT_W-1:0] chosen_port;

    member_pick_board board = new();
    int               quiet_cycles = 0;
    bit               burst_mode = 1'b0;

    always #5 clk = ~clk;

    lag_member_select_failover_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_command      (command),
        .i_flow_hash    (flow_hash),
        .i_slot_index   (slot_index),
        .i_port_number  (port_number),
        .i_port_running (port_running),
        .i_port_allowed (port_allowed),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_valid        (valid),
        .o_found        (found),
        .o_chosen_slot  (chosen_slot),
        .o_chosen_port  (chosen_port)
    );

    // monitor: results checked first, then the item taken at this edge is noted;
    // all values read here are the ones from before the edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (valid)
                board.check_result(found, chosen_slot, chosen_port);
            if (start && !busy)
                board.note_item(command, flow_hash, slot_index, port_number,
                                port_running, port_allowed);
            if (valid || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            // nothing moved for far too long: block is stuck
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // idle cycles before the next item; none at all in burst phases
    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 18);
    endfunction

    // present one item and hold it until the block takes it; start is only
    // lowered when a gap follows, so back-to-back items keep it high
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] hash,
                             input logic [SLOT_W-1:0] slot, input logic [PORT_W-1:0] port,
                             input logic run, input logic allow);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        flow_hash    <= hash;
        slot_index   <= slot;
        port_number  <= port;
        port_running <= run;
        port_allowed <= allow;
        do @(posedge clk); while (busy);
    endtask

    // stop sending, wait for every pending pick, then let the block settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // member count only changes with the block idle
    task automatic set_members(input logic [CNT_W-1:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_group_size(n);
    endtask

    // random item: mostly selects and flag churn on ports that are members
    task automatic send_random_item();
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [HASH_W-1:0] hash;
        logic [PORT_W-1:0] port;
        r = $urandom_range(0, 99);
        if (r < 45)      cmd = CMD_SELECT;
        else if (r < 65) cmd = CMD_WRITE;
        else if (r < 95) cmd = CMD_UPDATE;
        else             cmd = CMD_UNUSED;
        // hashes near the top of the range make hash + i wrap around
        if ($urandom_range(0, 3) == 0)
            hash = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
        else
            hash = $urandom;
        // ports of the member pool (slot * 17) most of the time
        if ($urandom_range(0, 3) != 0)
            port = 8'($urandom_range(0, 15) * 17);
        else
            port = 8'($urandom_range(0, 255));
        send_item(cmd, hash, 4'($urandom_range(0, 15)), port,
                  $urandom_range(0, 2) != 0, $urandom_range(0, 3) != 0);
    endtask

    initial begin
        int unsigned      phase_sizes [PHASES];
        logic [CNT_W-1:0] n;

        phase_sizes = '{16, 1, 31, 5, 0, 17, 3, 7, 2, 12, 0, 0};

        // synchronous reset, then wait out the flag clearing sweep
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (busy);

        // empty group and the dropped command
        set_members(5'd0);
        send_item(CMD_SELECT, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b0, 1'b0);
        send_item(CMD_UNUSED, $urandom, 4'($urandom), 8'($urandom), 1'b1, 1'b1);

        // fill every slot before any select can reach one; slot s gets port s*17
        for (int s = 0; s < MEMBER_SLOTS; s++)
            send_item(CMD_WRITE, $urandom, 4'(s), 8'(s * 17), 1'b0, 1'b0);

        set_members(5'd16);
        // all ports down after reset: no member usable
        send_item(CMD_SELECT, 32'h0000_0000, 4'd0, 8'd0, 1'b0, 1'b0);
        // slot 15 running but blocked, still nothing usable
        send_item(CMD_UPDATE, 32'h0, 4'd0, 8'd255, 1'b1, 1'b0);
        send_item(CMD_SELECT, 32'h0000_000F, 4'd0, 8'd0, 1'b0, 1'b0);
        // port 0 usable: start on blocked slot 15, wrap past the top to slot 0
        send_item(CMD_UPDATE, 32'h0, 4'd0, 8'd0, 1'b1, 1'b1);
        send_item(CMD_SELECT, 32'hFFFF_FFFF, 4'd0, 8'd0, 1'b0, 1'b0);

        // random phases over a range of member counts, beyond the table too
        for (int ph = 0; ph < PHASES; ph++) begin
            n = (ph >= PHASES - 2) ? 5'($urandom_range(0, 31)) : 5'(phase_sizes[ph]);
            set_members(n);
            burst_mode = ($urandom_range(0, 2) == 0);
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        drain();
        if (board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
